@@ hdl/tmq_pkg.sv @@
// Shared types and constants for the timer expiry queue.
// No dependencies; every other file of the block but tmq_ram uses this package.
package tmq_pkg;

   localparam int TIME_W = 63;
   localparam int IVL_W  = 32;
   localparam int SEQ_W  = 32;
   localparam int SLOT_W = 6;
   localparam int KIND_W = 2;
   localparam int STAT_W = 3;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd2;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] ST_CANCELLED = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] ST_FIRED     = 3'd4;
   localparam logic [STAT_W-1:0] ST_NONE      = 3'd5;

   // What a slot scan accumulates
   typedef enum logic [1:0] {
      SCAN_LIVE,   // earliest live expiry and first free slot
      SCAN_PRED,   // mark due slots, earliest expiry after re-arm
      SCAN_DUE     // earliest due slot
   } scan_mode_type;

   typedef struct packed {
      logic          start_scan;
      scan_mode_type scan_mode;
      logic          cancel_eval;
      logic          add_commit;
      logic          fire;
      logic          next_from_scan;
      logic          none_resp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic              scan_done;
      logic              found;
      logic              last;
      logic [KIND_W-1:0] kind;
   } dp_stat_type;

endpackage

@@ hdl/tmq_if.sv @@
// Request and response channel interfaces of the timer expiry queue.
// Depends on tmq_pkg for field widths.
interface tmq_req_if;
   logic                          valid;
   logic                          ready;
   logic [tmq_pkg::KIND_W-1:0]    kind;
   logic [tmq_pkg::TIME_W-1:0]    expiration_time;
   logic [tmq_pkg::IVL_W-1:0]     repeat_interval;
   logic [tmq_pkg::SLOT_W-1:0]    slot_index;
   logic [tmq_pkg::SEQ_W-1:0]     sequence_tag;
   logic [tmq_pkg::TIME_W-1:0]    current_time;

   modport source (output valid, kind, expiration_time, repeat_interval, slot_index,
                   sequence_tag, current_time, input ready);
   modport sink   (input valid, kind, expiration_time, repeat_interval, slot_index,
                   sequence_tag, current_time, output ready);
endinterface

interface tmq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tmq_pkg::STAT_W-1:0]    status;
   logic [tmq_pkg::SLOT_W-1:0]    result_slot;
   logic [tmq_pkg::SEQ_W-1:0]     result_sequence;
   logic                          earliest_changed;
   logic                          next_valid;
   logic [tmq_pkg::TIME_W-1:0]    next_expiration;
   logic                          last;

   modport source (output valid, status, result_slot, result_sequence, earliest_changed,
                   next_valid, next_expiration, last, input ready);
   modport sink   (input valid, status, result_slot, result_sequence, earliest_changed,
                   next_valid, next_expiration, last, output ready);
endinterface

@@ hdl/timer_expiry_queue.sv @@
// Top level of the timer expiry queue: ties the controller and datapath to
// the request and response channels. Depends on tmq_pkg, tmq_if, tmq_ctrl, tmq_dp.
//
// A table of TIMER_SLOTS timers. Words are taken one at a time; a cancel
// reads its own slot directly, and every other lookup is a scan that reads
// the slot memories one entry per cycle. An expire runs one scan to mark due
// timers and find the next expiry, then one more scan per fired timer,
// emitting a word after each (a nothing-due word if the first finds none);
// each further scan starts once the previous word is accepted. Kind 3 is
// accepted and ignored. No clearing pass is needed after reset.
module timer_expiry_queue #(
   parameter int TIMER_SLOTS = 16
) (
   input logic       clock,
   input logic       reset,
   tmq_req_if.sink   req_chan,
   tmq_rsp_if.source rsp_chan
);
   import tmq_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         take;

   assign take = req_chan.valid && req_chan.ready;

   tmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tmq_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .take                 (take),
      .cmd                  (cmd),
      .stat                 (stat),
      .in_kind              (req_chan.kind),
      .in_expiration_time   (req_chan.expiration_time),
      .in_repeat_interval   (req_chan.repeat_interval),
      .in_slot_index        (req_chan.slot_index),
      .in_sequence_tag      (req_chan.sequence_tag),
      .in_current_time      (req_chan.current_time),
      .out_status           (rsp_chan.status),
      .out_result_slot      (rsp_chan.result_slot),
      .out_result_sequence  (rsp_chan.result_sequence),
      .out_earliest_changed (rsp_chan.earliest_changed),
      .out_next_valid       (rsp_chan.next_valid),
      .out_next_expiration  (rsp_chan.next_expiration),
      .out_last             (rsp_chan.last)
   );
endmodule

@@ hdl/tmq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ hdl/tmq_dp.sv @@
// Datapath of the timer expiry queue: slot memories, live/due bits, scan
// accumulators and the response word register. Depends on tmq_pkg, tmq_ram.
module tmq_dp #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  tmq_pkg::ctrl_cmd_type         cmd,
   output tmq_pkg::dp_stat_type          stat,
   input  logic [tmq_pkg::KIND_W-1:0]    in_kind,
   input  logic [tmq_pkg::TIME_W-1:0]    in_expiration_time,
   input  logic [tmq_pkg::IVL_W-1:0]     in_repeat_interval,
   input  logic [tmq_pkg::SLOT_W-1:0]    in_slot_index,
   input  logic [tmq_pkg::SEQ_W-1:0]     in_sequence_tag,
   input  logic [tmq_pkg::TIME_W-1:0]    in_current_time,
   output logic [tmq_pkg::STAT_W-1:0]    out_status,
   output logic [tmq_pkg::SLOT_W-1:0]    out_result_slot,
   output logic [tmq_pkg::SEQ_W-1:0]     out_result_sequence,
   output logic                          out_earliest_changed,
   output logic                          out_next_valid,
   output logic [tmq_pkg::TIME_W-1:0]    out_next_expiration,
   output logic                          out_last
);
   import tmq_pkg::*;

   localparam int AW = $clog2(TIMER_SLOTS);
   localparam int CW = $clog2(TIMER_SLOTS + 1);

   // Latched request word
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [TIME_W-1:0] exp_req_ff, exp_req_in;
   logic [IVL_W-1:0]  ivl_req_ff, ivl_req_in;
   logic [SLOT_W-1:0] slot_req_ff, slot_req_in;
   logic [SEQ_W-1:0]  tag_ff, tag_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // Table control state
   logic [TIMER_SLOTS-1:0] live_ff, live_in;
   logic [TIMER_SLOTS-1:0] due_ff, due_in;
   logic [SEQ_W-1:0]       seq_ctr_ff, seq_ctr_in;

   // Scan sequencing
   logic              scanning_ff, scanning_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              pv_ff, pv_in;
   logic [AW-1:0]     pidx_ff, pidx_in;
   scan_mode_type     mode_ff, mode_in;

   // Scan accumulators
   logic              found_ff, found_in;
   logic [TIME_W-1:0] best_ff, best_in;
   logic [AW-1:0]     best_idx_ff, best_idx_in;
   logic [SEQ_W-1:0]  best_seq_ff, best_seq_in;
   logic [IVL_W-1:0]  best_ivl_ff, best_ivl_in;
   logic              free_found_ff, free_found_in;
   logic [AW-1:0]     free_ff, free_in;

   // Response word
   logic              nxt_valid_ff, nxt_valid_in;
   logic [TIME_W-1:0] nxt_ff, nxt_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0] rslot_ff, rslot_in;
   logic [SEQ_W-1:0]  rseq_ff, rseq_in;
   logic              chg_ff, chg_in;
   logic              last_ff, last_in;

   // Memory ports
   logic [AW-1:0]     raddr, waddr;
   logic [TIME_W-1:0] rd_exp, wr_exp;
   logic [IVL_W-1:0]  rd_ivl;
   logic [SEQ_W-1:0]  rd_seq;
   logic              exp_we, add_we;

   // Saturating re-arm sums
   logic [TIME_W:0]   sum_scan, sum_fire;
   logic [TIME_W-1:0] sat_scan, sat_fire;

   logic              in_range, hit, changed;
   logic              cand_ok;
   logic [TIME_W-1:0] cand;
   logic [TIMER_SLOTS-1:0] rest_due;
   logic [AW-1:0]     slot_a;

   assign slot_a   = slot_req_ff[AW-1:0];
   assign in_range = {1'b0, slot_req_ff} < (SLOT_W+1)'(TIMER_SLOTS);

   assign sum_scan = {1'b0, now_ff} + (TIME_W+1)'(rd_ivl);
   assign sat_scan = sum_scan[TIME_W] ? TIME_MAX : sum_scan[TIME_W-1:0];
   assign sum_fire = {1'b0, now_ff} + (TIME_W+1)'(best_ivl_ff);
   assign sat_fire = sum_fire[TIME_W] ? TIME_MAX : sum_fire[TIME_W-1:0];

   assign raddr  = scanning_ff ? idx_ff[AW-1:0] : slot_a;
   assign add_we = cmd.add_commit && free_found_ff;
   assign exp_we = add_we || (cmd.fire && (best_ivl_ff != '0));
   assign waddr  = cmd.add_commit ? free_ff : best_idx_ff;
   assign wr_exp = cmd.add_commit ? exp_req_ff : sat_fire;

   tmq_ram #(.WIDTH(TIME_W), .DEPTH(TIMER_SLOTS)) u_exp_ram (
      .clock(clock), .we(exp_we), .waddr(waddr), .wdata(wr_exp),
      .raddr(raddr), .rdata(rd_exp));

   tmq_ram #(.WIDTH(IVL_W), .DEPTH(TIMER_SLOTS)) u_ivl_ram (
      .clock(clock), .we(add_we), .waddr(waddr), .wdata(ivl_req_ff),
      .raddr(raddr), .rdata(rd_ivl));

   tmq_ram #(.WIDTH(SEQ_W), .DEPTH(TIMER_SLOTS)) u_seq_ram (
      .clock(clock), .we(add_we), .waddr(waddr), .wdata(seq_ctr_ff + 1'b1),
      .raddr(raddr), .rdata(rd_seq));

   // Next-state logic
   always_comb begin
      kind_in = kind_ff;  exp_req_in = exp_req_ff;  ivl_req_in = ivl_req_ff;
      slot_req_in = slot_req_ff;  tag_in = tag_ff;  now_in = now_ff;
      live_in = live_ff;  due_in = due_ff;  seq_ctr_in = seq_ctr_ff;
      scanning_in = scanning_ff;  idx_in = idx_ff;  pv_in = 1'b0;  pidx_in = pidx_ff;
      mode_in = mode_ff;
      found_in = found_ff;  best_in = best_ff;  best_idx_in = best_idx_ff;
      best_seq_in = best_seq_ff;  best_ivl_in = best_ivl_ff;
      free_found_in = free_found_ff;  free_in = free_ff;
      nxt_valid_in = nxt_valid_ff;  nxt_in = nxt_ff;
      status_in = status_ff;  rslot_in = rslot_ff;  rseq_in = rseq_ff;
      chg_in = chg_ff;  last_in = last_ff;
      cand_ok = 1'b0;  cand = rd_exp;
      hit = in_range && live_ff[slot_a] && (rd_seq == tag_ff);
      changed = !found_ff || (exp_req_ff < best_ff);
      rest_due = due_ff;
      rest_due[best_idx_ff] = 1'b0;

      // Latch the accepted word
      if (take) begin
         kind_in = in_kind;  exp_req_in = in_expiration_time;
         ivl_req_in = in_repeat_interval;  slot_req_in = in_slot_index;
         tag_in = in_sequence_tag;  now_in = in_current_time;
      end

      // Walk the slot memories one address per cycle
      if (scanning_ff) begin
         pv_in   = 1'b1;
         pidx_in = idx_ff[AW-1:0];
         idx_in  = idx_ff + 1'b1;
         if (idx_ff == CW'(TIMER_SLOTS - 1)) begin
            scanning_in = 1'b0;
         end
      end

      // Fold in the slot read last cycle
      if (pv_ff) begin
         case (mode_ff)
            SCAN_LIVE: begin
               if (live_ff[pidx_ff] && (!found_ff || rd_exp < best_ff)) begin
                  found_in = 1'b1;
                  best_in  = rd_exp;
               end
               if (!live_ff[pidx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = pidx_ff;
               end
            end
            SCAN_PRED: begin
               if (live_ff[pidx_ff]) begin
                  if (rd_exp <= now_ff) begin
                     due_in[pidx_ff] = 1'b1;
                     cand_ok = (rd_ivl != '0);
                     cand    = sat_scan;
                  end else begin
                     cand_ok = 1'b1;
                  end
               end
               if (cand_ok && (!found_ff || cand < best_ff)) begin
                  found_in = 1'b1;
                  best_in  = cand;
               end
            end
            SCAN_DUE: begin
               if (due_ff[pidx_ff] && (!found_ff || rd_exp < best_ff)) begin
                  found_in    = 1'b1;
                  best_in     = rd_exp;
                  best_idx_in = pidx_ff;
                  best_seq_in = rd_seq;
                  best_ivl_in = rd_ivl;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.next_from_scan) begin
         nxt_valid_in = found_ff;
         nxt_in       = found_ff ? best_ff : '0;
      end

      if (cmd.start_scan) begin
         scanning_in   = 1'b1;
         idx_in        = '0;
         mode_in       = cmd.scan_mode;
         found_in      = 1'b0;
         free_found_in = 1'b0;
         if (cmd.scan_mode == SCAN_PRED) begin
            due_in = '0;
         end
      end

      // Cancel: compare the stored tag
      if (cmd.cancel_eval) begin
         if (hit) begin
            live_in[slot_a] = 1'b0;
         end
         status_in = hit ? ST_CANCELLED : ST_NOT_FOUND;
         rslot_in  = slot_req_ff;
         rseq_in   = tag_ff;
         chg_in    = 1'b0;
         last_in   = 1'b1;
      end

      // Add: take the first free slot, or report the table full
      if (cmd.add_commit) begin
         last_in = 1'b1;
         if (free_found_ff) begin
            seq_ctr_in       = seq_ctr_ff + 1'b1;
            live_in[free_ff] = 1'b1;
            status_in    = ST_ADDED;
            rslot_in     = SLOT_W'(free_ff);
            rseq_in      = seq_ctr_ff + 1'b1;
            chg_in       = changed;
            nxt_valid_in = 1'b1;
            nxt_in       = changed ? exp_req_ff : best_ff;
         end else begin
            status_in    = ST_FULL;
            rslot_in     = '0;
            rseq_in      = '0;
            chg_in       = 1'b0;
            nxt_valid_in = found_ff;
            nxt_in       = found_ff ? best_ff : '0;
         end
      end

      // Expire: fire the earliest due slot, re-arm or free it
      if (cmd.fire) begin
         due_in[best_idx_ff] = 1'b0;
         if (best_ivl_ff == '0) begin
            live_in[best_idx_ff] = 1'b0;
         end
         status_in = ST_FIRED;
         rslot_in  = SLOT_W'(best_idx_ff);
         rseq_in   = best_seq_ff;
         chg_in    = 1'b0;
         last_in   = (rest_due == '0);
      end

      if (cmd.none_resp) begin
         status_in = ST_NONE;
         rslot_in  = '0;
         rseq_in   = '0;
         chg_in    = 1'b0;
         last_in   = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff     <= '0;
         due_ff      <= '0;
         seq_ctr_ff  <= '0;
         scanning_ff <= 1'b0;
         pv_ff       <= 1'b0;
      end else begin
         live_ff     <= live_in;
         due_ff      <= due_in;
         seq_ctr_ff  <= seq_ctr_in;
         scanning_ff <= scanning_in;
         pv_ff       <= pv_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;  exp_req_ff <= exp_req_in;  ivl_req_ff <= ivl_req_in;
      slot_req_ff <= slot_req_in;  tag_ff <= tag_in;  now_ff <= now_in;
      idx_ff <= idx_in;  pidx_ff <= pidx_in;  mode_ff <= mode_in;
      found_ff <= found_in;  best_ff <= best_in;  best_idx_ff <= best_idx_in;
      best_seq_ff <= best_seq_in;  best_ivl_ff <= best_ivl_in;
      free_found_ff <= free_found_in;  free_ff <= free_in;
      nxt_valid_ff <= nxt_valid_in;  nxt_ff <= nxt_in;
      status_ff <= status_in;  rslot_ff <= rslot_in;  rseq_ff <= rseq_in;
      chg_ff <= chg_in;  last_ff <= last_in;
   end

   assign stat.scan_done = !scanning_ff && !pv_ff;
   assign stat.found     = found_ff;
   assign stat.last      = last_ff;
   assign stat.kind      = kind_ff;

   assign out_status           = status_ff;
   assign out_result_slot      = rslot_ff;
   assign out_result_sequence  = rseq_ff;
   assign out_earliest_changed = chg_ff;
   assign out_next_valid       = nxt_valid_ff;
   assign out_next_expiration  = nxt_ff;
   assign out_last             = last_ff;
endmodule

@@ hdl/tmq_ctrl.sv @@
// Controller of the timer expiry queue: sequences scans, updates and the
// response handshake. Depends on tmq_pkg.
module tmq_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [tmq_pkg::KIND_W-1:0] req_kind,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  tmq_pkg::dp_stat_type       stat,
   output tmq_pkg::ctrl_cmd_type      cmd
);
   import tmq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CAN_RD, S_CAN_EVAL, S_SCAN_WAIT, S_PRED_WAIT,
      S_DUE_WAIT, S_SETTLE, S_RESP
   } state_type;

   state_type    state_ff;
   ctrl_cmd_type cmd_ff;
   logic         ready_ff;
   logic         valid_ff;

   // State, handshake and command registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cmd_ff   <= '0;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         cmd_ff <= '0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && ready_ff) begin
                  case (req_kind)
                     KIND_ADD: begin
                        ready_ff          <= 1'b0;
                        cmd_ff.start_scan <= 1'b1;
                        cmd_ff.scan_mode  <= SCAN_LIVE;
                        state_ff          <= S_SCAN_WAIT;
                     end
                     KIND_CANCEL: begin
                        ready_ff <= 1'b0;
                        state_ff <= S_CAN_RD;
                     end
                     KIND_EXPIRE: begin
                        ready_ff          <= 1'b0;
                        cmd_ff.start_scan <= 1'b1;
                        cmd_ff.scan_mode  <= SCAN_PRED;
                        state_ff          <= S_PRED_WAIT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_CAN_RD: begin
               cmd_ff.cancel_eval <= 1'b1;
               state_ff           <= S_CAN_EVAL;
            end
            S_CAN_EVAL: begin
               cmd_ff.start_scan <= 1'b1;
               cmd_ff.scan_mode  <= SCAN_LIVE;
               state_ff          <= S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
               if (!cmd_ff.start_scan && stat.scan_done) begin
                  if (stat.kind == KIND_ADD) begin
                     cmd_ff.add_commit <= 1'b1;
                  end else begin
                     cmd_ff.next_from_scan <= 1'b1;
                  end
                  state_ff <= S_SETTLE;
               end
            end
            S_PRED_WAIT: begin
               if (!cmd_ff.start_scan && stat.scan_done) begin
                  cmd_ff.next_from_scan <= 1'b1;
                  cmd_ff.start_scan     <= 1'b1;
                  cmd_ff.scan_mode      <= SCAN_DUE;
                  state_ff              <= S_DUE_WAIT;
               end
            end
            S_DUE_WAIT: begin
               if (!cmd_ff.start_scan && stat.scan_done) begin
                  if (stat.found) begin
                     cmd_ff.fire <= 1'b1;
                  end else begin
                     cmd_ff.none_resp <= 1'b1;
                  end
                  state_ff <= S_SETTLE;
               end
            end
            S_SETTLE: begin
               valid_ff <= 1'b1;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp_ready) begin
                  valid_ff <= 1'b0;
                  if (stat.last) begin
                     ready_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     cmd_ff.start_scan <= 1'b1;
                     cmd_ff.scan_mode  <= SCAN_DUE;
                     state_ff          <= S_DUE_WAIT;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign cmd       = cmd_ff;
   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;
endmodule

@@ hdl/tmq_checker.sv @@
// Port-level checks on the response word of the timer expiry queue, and the
// bind that attaches them. Depends on tmq_pkg and timer_expiry_queue.
module tmq_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic [tmq_pkg::STAT_W-1:0] status,
   input logic [tmq_pkg::SLOT_W-1:0] result_slot,
   input logic [tmq_pkg::SEQ_W-1:0]  result_sequence,
   input logic                       earliest_changed,
   input logic                       next_valid,
   input logic [tmq_pkg::TIME_W-1:0] next_expiration,
   input logic                       last
);
   import tmq_pkg::*;

   // A successful add leaves a timer armed and ends its item
   a_added_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_ADDED |-> next_valid && last)
      else $error("add response without armed timer or last");

   // A word with no next expiry reports it as zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !next_valid |-> next_expiration == '0)
      else $error("next_expiration nonzero with no timer armed");

   // Only an add word can flag a change of the earliest expiry
   a_changed_add: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_ADDED |-> !earliest_changed)
      else $error("earliest_changed on a non-add word");

   // Full and nothing-due words carry no slot identity and end their item
   a_no_ident: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ST_FULL || status == ST_NONE)
      |-> result_slot == '0 && result_sequence == '0 && last)
      else $error("full or none word carries a slot");
endmodule

bind timer_expiry_queue tmq_checker u_tmq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .status           (rsp_chan.status),
   .result_slot      (rsp_chan.result_slot),
   .result_sequence  (rsp_chan.result_sequence),
   .earliest_changed (rsp_chan.earliest_changed),
   .next_valid       (rsp_chan.next_valid),
   .next_expiration  (rsp_chan.next_expiration),
   .last             (rsp_chan.last)
);
